// ===== design/ufx_pkg.sv =====
// ----------------------------------------------------------------------------
// ufx_pkg
// shared widths, codes and types of the update sequence fixup block
// ----------------------------------------------------------------------------
package ufx_pkg;

    localparam int DATA_W     = 16;
    localparam int BYTE_W     = 13;
    localparam int UC_W       = 16;
    localparam int POS_W      = 12;
    localparam int SWC_W      = 12;
    localparam int WRAP_W     = 11;
    localparam int PROD_W     = UC_W + BYTE_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USA_OFFSET   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USA_COUNT    = 8'd3;

    localparam logic [BYTE_W-1:0] RST_SECTOR_BYTES = 13'd512;
    localparam logic [BYTE_W-1:0] RST_RECORD_BYTES = 13'd1024;
    localparam logic [BYTE_W-1:0] RST_USA_OFFSET   = 13'd48;
    localparam logic [UC_W-1:0]   RST_USA_COUNT    = 16'd3;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_MISMATCH     = 2'd1,
        ST_BAD_GEOMETRY = 2'd2,
        ST_UNSUPPORTED  = 2'd3
    } status_t;

    typedef struct packed {
        status_t              code;
        logic [POS_W-1:0]     frame;
        logic [POS_W-1:0]     usa_word;
        logic [POS_W-1:0]     sector_words;
        logic [UC_W-1:0]      usa_count;
    } geo_info_t;

endpackage

// ===== design/ufx_channels.sv =====
// ----------------------------------------------------------------------------
// ufx channels
// valid/ready channels for record words, result words and register writes
// ----------------------------------------------------------------------------
interface ufx_in_if import ufx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface ufx_out_if import ufx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_word;
    logic              last_word;
    logic [1:0]        status;

    modport source (output valid, output out_word, output last_word, output status,
                    input ready);
    modport sink   (input valid, input out_word, input last_word, input status,
                    output ready);
endinterface

interface ufx_cfg_if import ufx_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ufx_ram.sv =====
// ----------------------------------------------------------------------------
// ufx_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ufx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ufx_geometry.sv =====
// ----------------------------------------------------------------------------
// ufx_geometry
// register file and registered geometry check of the record layout
// ----------------------------------------------------------------------------
module ufx_geometry import ufx_pkg::*; #(
    parameter int MAX_RECORD_BYTES = 4096,
    parameter int MAX_USA_WORDS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ufx_cfg_if.sink   cfg,
    output geo_info_t geo,
    output logic      settled
);

    localparam logic [1:0] SETTLE_LOAD = 2'd2;

    logic [BYTE_W-1:0] sb_reg, sb_next;
    logic [BYTE_W-1:0] rb_reg, rb_next;
    logic [BYTE_W-1:0] uo_reg, uo_next;
    logic [UC_W-1:0]   uc_reg, uc_next;
    logic [1:0]        settle_reg, settle_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    geo_info_t         geo_reg, geo_next;

    logic              cfg_write;
    logic [BYTE_W-1:0] avail_bytes;
    logic [17:0]       usa_end;
    logic              rb_over;
    logic              bad;
    logic              unsup;
    logic [BYTE_W-1:0] rb_clip;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        sb_next = sb_reg;
        rb_next = rb_reg;
        uo_next = uo_reg;
        uc_next = uc_reg;
        settle_next = (settle_reg != 2'd0) ? settle_reg - 2'd1 : settle_reg;
        if (cfg_write)
        begin
            settle_next = SETTLE_LOAD;
            case (cfg.index)
                CFG_SECTOR_BYTES: sb_next = cfg.data[BYTE_W-1:0];
                CFG_RECORD_BYTES: rb_next = cfg.data[BYTE_W-1:0];
                CFG_USA_OFFSET:   uo_next = cfg.data[BYTE_W-1:0];
                CFG_USA_COUNT:    uc_next = cfg.data[UC_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg     <= RST_SECTOR_BYTES;
            rb_reg     <= RST_RECORD_BYTES;
            uo_reg     <= RST_USA_OFFSET;
            uc_reg     <= RST_USA_COUNT;
            settle_reg <= SETTLE_LOAD;
        end
        else
        begin
            sb_reg     <= sb_next;
            rb_reg     <= rb_next;
            uo_reg     <= uo_next;
            uc_reg     <= uc_next;
            settle_reg <= settle_next;
        end
    end

    // sectors times sector size must give the record length
    assign prod_next = PROD_W'(UC_W'(uc_reg - 16'd1) * sb_reg);

    always_comb
    begin
        avail_bytes = rb_reg - uo_reg;
        usa_end     = 18'(uo_reg) + 18'({uc_reg, 1'b0}) + 18'd2;
        rb_over     = 32'(rb_reg) > 32'(MAX_RECORD_BYTES);
        bad = (sb_reg == '0) || (rb_reg == '0) || (uc_reg < 16'd2)
            || (prod_reg != PROD_W'(rb_reg)) || (uo_reg > rb_reg)
            || (uc_reg > UC_W'(avail_bytes[BYTE_W-1:1]));
        unsup = rb_over || sb_reg[0] || uo_reg[0]
            || (32'(uc_reg) > 32'(MAX_USA_WORDS)) || (usa_end > 18'(sb_reg));
        if (bad)
        begin
            geo_next.code = ST_BAD_GEOMETRY;
        end
        else if (unsup)
        begin
            geo_next.code = ST_UNSUPPORTED;
        end
        else
        begin
            geo_next.code = ST_OK;
        end
        rb_clip = rb_over ? BYTE_W'(MAX_RECORD_BYTES) : rb_reg;
        geo_next.frame = rb_clip[BYTE_W-1:1];
        if (geo_next.frame == '0)
        begin
            geo_next.frame = POS_W'(1);
        end
        geo_next.usa_word     = uo_reg[BYTE_W-1:1];
        geo_next.sector_words = sb_reg[BYTE_W-1:1];
        geo_next.usa_count    = uc_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        geo_reg  <= geo_next;
    end

    assign geo     = geo_reg;
    assign settled = (settle_reg == 2'd0);

    a_write_unsettles: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !settled ##1 !settled)
        else $error("geometry reported settled right after a register write");

    a_settle_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write && !settled |=> settle_reg == $past(settle_reg) - 2'd1)
        else $error("geometry settle count did not advance");

    a_frame_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        settled |-> geo.frame != '0)
        else $error("record frame of zero words");

endmodule

// ===== design/ufx_sequencer.sv =====
// ----------------------------------------------------------------------------
// ufx_sequencer
// word counters, array capture into the replacement ram and tail fixup
// ----------------------------------------------------------------------------
module ufx_sequencer import ufx_pkg::*; #(
    parameter int MAX_USA_WORDS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  geo_info_t geo,
    input  logic      settled,
    ufx_in_if.sink    record,
    ufx_out_if.source result
);

    localparam int AW = $clog2(MAX_USA_WORDS);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SWC_W-1:0]  swc_reg, swc_next;
    logic [AW-1:0]     sidx_reg, sidx_next;
    logic [DATA_W-1:0] seq_reg, seq_next;
    logic              mismatch_reg, mismatch_next;

    logic              s1_valid_reg, s1_valid_next;
    logic [DATA_W-1:0] s1_word_reg, s1_word_next;
    logic              s1_replace_reg, s1_replace_next;
    logic              s1_last_reg, s1_last_next;
    status_t           s1_status_reg, s1_status_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_word_reg, out_word_next;
    logic              out_last_reg, out_last_next;
    status_t           out_status_reg, out_status_next;

    logic              accept;
    logic              s1_move;
    logic              good;
    logic [DATA_W-1:0] w;
    logic [POS_W-1:0]  usa_delta;
    logic [POS_W-1:0]  slot;
    logic              is_seq;
    logic              in_usa;
    logic [DATA_W-1:0] seq_eff;
    logic              tail;
    logic              check;
    logic              fwd;
    logic              replace;
    logic              mismatch_item;
    logic              last;
    status_t           item_status;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;

    assign s1_move      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign record.ready = settled && (!s1_valid_reg || s1_move);
    assign accept       = record.valid && record.ready;
    assign w            = record.data_word;

    always_comb
    begin
        good      = (geo.code == ST_OK);
        usa_delta = pos_reg - geo.usa_word;
        slot      = usa_delta - POS_W'(1);
        is_seq    = good && (pos_reg == geo.usa_word);
        in_usa    = good && (pos_reg > geo.usa_word) && (UC_W'(usa_delta) < geo.usa_count);
        ram_we    = accept && in_usa && (32'(slot) < 32'(MAX_USA_WORDS));
        ram_waddr = slot[AW-1:0];
        seq_eff   = is_seq ? w : seq_reg;
        tail      = good && ((13'(swc_reg) + 13'd1) >= 13'(geo.sector_words));
        check     = tail && !mismatch_reg;
        // same entry written by this word: the stored value is the word itself
        fwd       = ram_we && (ram_waddr == sidx_reg);
        replace   = check && (w == seq_eff) && !fwd;
        ram_re    = accept && replace;
        mismatch_item = mismatch_reg || (check && (w != seq_eff));
        last      = (13'(pos_reg) + 13'd1) >= 13'(geo.frame);
        if (!last)
        begin
            item_status = ST_OK;
        end
        else if (geo.code != ST_OK)
        begin
            item_status = geo.code;
        end
        else if (mismatch_item)
        begin
            item_status = ST_MISMATCH;
        end
        else
        begin
            item_status = ST_OK;
        end

        pos_next      = pos_reg;
        swc_next      = swc_reg;
        sidx_next     = sidx_reg;
        seq_next      = seq_reg;
        mismatch_next = mismatch_reg;
        if (accept)
        begin
            seq_next = seq_eff;
            if (last)
            begin
                pos_next      = '0;
                swc_next      = '0;
                sidx_next     = '0;
                mismatch_next = 1'b0;
            end
            else
            begin
                pos_next      = pos_reg + POS_W'(1);
                mismatch_next = mismatch_item;
                if (!good)
                begin
                    swc_next = SWC_W'(WRAP_W'(swc_reg[WRAP_W-1:0] + WRAP_W'(1)));
                end
                else if (tail)
                begin
                    swc_next = '0;
                end
                else
                begin
                    swc_next = swc_reg + SWC_W'(1);
                end
                if (tail && (32'(sidx_reg) < 32'(MAX_USA_WORDS - 1)))
                begin
                    sidx_next = sidx_reg + AW'(1);
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_word_next    = s1_word_reg;
        s1_replace_next = s1_replace_reg;
        s1_last_next    = s1_last_reg;
        s1_status_next  = s1_status_reg;
        if (accept)
        begin
            s1_valid_next   = 1'b1;
            s1_word_next    = w;
            s1_replace_next = replace;
            s1_last_next    = last;
            s1_status_next  = item_status;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if (s1_move)
        begin
            out_valid_next  = 1'b1;
            out_word_next   = s1_replace_reg ? ram_rdata : s1_word_reg;
            out_last_next   = s1_last_reg;
            out_status_next = s1_status_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            swc_reg       <= '0;
            sidx_reg      <= '0;
            seq_reg       <= '0;
            mismatch_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            swc_reg       <= swc_next;
            sidx_reg      <= sidx_next;
            seq_reg       <= seq_next;
            mismatch_reg  <= mismatch_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg     <= s1_word_next;
        s1_replace_reg  <= s1_replace_next;
        s1_last_reg     <= s1_last_next;
        s1_status_reg   <= s1_status_next;
        out_word_reg    <= out_word_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
    end

    ufx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_USA_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (w),
        .re    (ram_re),
        .raddr (sidx_reg),
        .rdata (ram_rdata)
    );

    assign result.valid     = out_valid_reg;
    assign result.out_word  = out_word_reg;
    assign result.last_word = out_last_reg;
    assign result.status    = out_status_reg;

    a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == sidx_reg)))
        else $error("replacement store read and written at the same entry");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_word_reg)
            && $stable(s1_replace_reg))
        else $error("stalled stage one transaction was lost or changed");

    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.last_word |-> result.status == ST_OK)
        else $error("status reported on a word that is not the last");

    a_record_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> pos_reg == '0 && sidx_reg == '0 && !mismatch_reg)
        else $error("record counters not cleared after the last word");

endmodule

// ===== design/update_sequence_fixup_core.sv =====
// ----------------------------------------------------------------------------
// update_sequence_fixup_core
// update sequence array capture and sector tail fixup on a record word stream
// ----------------------------------------------------------------------------
// record carries the 16-bit record words in order; result returns every word
// with the same index, sector tails replaced from the captured array, and
// last_word plus status on the final word of the record
// cfg writes sector_bytes, record_bytes, usa_offset and usa_count by index
// a word accepted on record is registered in stage one and then in the output
// register, which drives result
// throughput: one word per cycle while result is not stalled; the per-word
// counters and the single replacement ram access (one write or one registered
// read) set that figure; after a register write record.ready stays low
// until the geometry check has settled
// reset restores the default layout, clears counters and both stages, and
// holds record.ready low until the geometry check has settled
// a stalled result fills the output register and stage one, then
// record.ready drops until result.ready returns
// ----------------------------------------------------------------------------
module update_sequence_fixup_core import ufx_pkg::*; #(
    parameter int MAX_RECORD_BYTES = 4096,
    parameter int MAX_USA_WORDS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ufx_in_if.sink    record,
    ufx_out_if.source result,
    ufx_cfg_if.sink   cfg
);

    geo_info_t geo;
    logic      settled;

    ufx_geometry #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
        .MAX_USA_WORDS    (MAX_USA_WORDS)
    ) u_geometry (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .geo     (geo),
        .settled (settled)
    );

    ufx_sequencer #(
        .MAX_USA_WORDS (MAX_USA_WORDS)
    ) u_sequencer (
        .clk     (clk),
        .rst_n   (rst_n),
        .geo     (geo),
        .settled (settled),
        .record  (record),
        .result  (result)
    );

endmodule

// ===== dv/update_sequence_fixup_core_test.sv =====
// ----------------------------------------------------------------------------
// update_sequence_fixup_core_test
// self-checking bench for update sequence capture and sector tail fixup
// ----------------------------------------------------------------------------
// a record under the reset layout comes first, then a table of short records
// that walks the ok, mismatch, bad geometry and unsupported layout outcomes,
// then random layouts: mostly well-formed records with random content, some
// broken layouts and random register values, and one long four-sector record.
// every result transaction is compared with a table entry or a bit-accurate prediction; the
// sender pauses between bursts and the receiver stalls on patterns of its own
// ----------------------------------------------------------------------------
module update_sequence_fixup_core_test;
    import ufx_pkg::*;

    localparam int unsigned MAX_REC_BYTES = 4096;
    localparam int unsigned MAX_USA       = 16;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          QUIET_LIMIT   = 1000;
    localparam int          ITEM_TARGET   = 1700;
    localparam int          LONG_REC_BYTES = 1024;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              last;
        status_t           status;
    } fixup_result_t;

    typedef enum logic {ROW_LAYOUT, ROW_WORD} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [15:0]       sb, rb, off, cnt;
        logic [DATA_W-1:0] word;
        logic              typed;
        fixup_result_t     want;
    } step_row_t;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_PERIODIC} ready_style_t;

    logic clk;
    logic rst_n;

    ufx_in_if  rec_ch ();
    ufx_out_if res_ch ();
    ufx_cfg_if cfg_ch ();

    update_sequence_fixup_core #(
        .MAX_RECORD_BYTES(MAX_REC_BYTES),
        .MAX_USA_WORDS(MAX_USA)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .record(rec_ch),
        .result(res_ch),
        .cfg(cfg_ch)
    );

    // register copies
    logic [BYTE_W-1:0] m_sector_bytes;
    logic [BYTE_W-1:0] m_record_bytes;
    logic [BYTE_W-1:0] m_usa_offset;
    logic [UC_W-1:0]   m_usa_count;

    // fixup state
    logic [10:0]       rec_pos;
    logic [10:0]       sect_pos;
    logic [3:0]        sect_idx;
    logic [DATA_W-1:0] seq_word;
    logic [DATA_W-1:0] tail_orig [MAX_USA];
    status_t           tail_fault;

    fixup_result_t pending_results [$];
    step_row_t     directed_steps [$];

    int  failures;
    int  words_sent;
    int  records_seen;
    int  layouts_written;
    int  tails_corrupted;
    int  burst_left;
    bit  steady;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic status_t layout_status();
        int unsigned sb, rb, uo, uc;
        sb = m_sector_bytes;
        rb = m_record_bytes;
        uo = m_usa_offset;
        uc = m_usa_count;
        if (sb == 0)
            return ST_BAD_GEOMETRY;
        if (rb == 0 || (rb % sb) != 0)
            return ST_BAD_GEOMETRY;
        if (uc < 2)
            return ST_BAD_GEOMETRY;
        if (uc != rb / sb + 1)
            return ST_BAD_GEOMETRY;
        if (uo > rb)
            return ST_BAD_GEOMETRY;
        if (uc > (rb - uo) / 2)
            return ST_BAD_GEOMETRY;
        if (rb > MAX_REC_BYTES)
            return ST_UNSUPPORTED;
        if ((sb % 2) != 0 || (uo % 2) != 0)
            return ST_UNSUPPORTED;
        if (uc > MAX_USA)
            return ST_UNSUPPORTED;
        if (uo + 2 * uc + 2 > sb)
            return ST_UNSUPPORTED;
        return ST_OK;
    endfunction

    function automatic int unsigned record_frame();
        int unsigned rb;
        rb = (m_record_bytes > MAX_REC_BYTES) ? MAX_REC_BYTES : m_record_bytes;
        return ((rb >> 1) == 0) ? 1 : (rb >> 1);
    endfunction

    function automatic fixup_result_t fix_word(input logic [DATA_W-1:0] w);
        fixup_result_t r;
        status_t       geo;
        int unsigned   frame, pos, uw, sw, k;
        geo = layout_status();
        frame = record_frame();
        pos = rec_pos;
        r.word = w;
        r.last = 1'b0;
        r.status = ST_OK;
        if (geo == ST_OK)
        begin
            uw = m_usa_offset >> 1;
            sw = m_sector_bytes >> 1;
            if (pos == uw)
                seq_word = w;
            else if (pos > uw && pos - uw < m_usa_count)
            begin
                k = pos - uw - 1;
                if (k < MAX_USA)
                    tail_orig[k] = w;
            end
            if (sect_pos + 1 >= sw)
            begin
                if (tail_fault == ST_OK)
                begin
                    if (w != seq_word)
                        tail_fault = ST_MISMATCH;
                    else if (sect_idx < MAX_USA)
                        r.word = tail_orig[sect_idx];
                end
                if (sect_idx < MAX_USA - 1)
                    sect_idx = sect_idx + 1'b1;
                sect_pos = '0;
            end
            else
                sect_pos = sect_pos + 1'b1;
        end
        else
            sect_pos = sect_pos + 1'b1;
        if (pos + 1 >= frame)
        begin
            r.last = 1'b1;
            r.status = (geo != ST_OK) ? geo : tail_fault;
            rec_pos = '0;
            sect_pos = '0;
            sect_idx = '0;
            tail_fault = ST_OK;
        end
        else
            rec_pos = rec_pos + 1'b1;
        return r;
    endfunction

    function automatic step_row_t row_layout(input int unsigned sb, rb, off, cnt);
        step_row_t r;
        r = '0;
        r.kind = ROW_LAYOUT;
        r.sb = 16'(sb);
        r.rb = 16'(rb);
        r.off = 16'(off);
        r.cnt = 16'(cnt);
        return r;
    endfunction

    function automatic step_row_t row_word(input logic [DATA_W-1:0] w);
        step_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.word = w;
        return r;
    endfunction

    function automatic step_row_t row_check(input logic [DATA_W-1:0] w, ew,
                                            input logic el, input status_t es);
        step_row_t r;
        r = row_word(w);
        r.typed = 1'b1;
        r.want.word = ew;
        r.want.last = el;
        r.want.status = es;
        return r;
    endfunction

    task automatic send_word(input logic [DATA_W-1:0] w, input logic typed,
                             input fixup_result_t typed_want);
        fixup_result_t predicted;
        int            gap;
        predicted = fix_word(w);
        pending_results.push_back(typed ? typed_want : predicted);
        rec_ch.valid <= 1'b1;
        rec_ch.data_word <= w;
        do @(posedge clk); while (!rec_ch.ready);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = steady ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                rec_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_SECTOR_BYTES: m_sector_bytes = val[BYTE_W-1:0];
            CFG_RECORD_BYTES: m_record_bytes = val[BYTE_W-1:0];
            CFG_USA_OFFSET:   m_usa_offset = val[BYTE_W-1:0];
            CFG_USA_COUNT:    m_usa_count = val;
            default: ;
        endcase
    endtask

    task automatic program_layout(input int unsigned sb, rb, off, cnt,
                                  input logic [3:0] which, input bit stray);
        rec_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (which[0])
            reg_write(CFG_SECTOR_BYTES, 16'(sb));
        if (which[1])
            reg_write(CFG_RECORD_BYTES, 16'(rb));
        if (which[2])
            reg_write(CFG_USA_OFFSET, 16'(off));
        if (which[3])
            reg_write(CFG_USA_COUNT, 16'(cnt));
        if (stray)
            reg_write(CFG_IDX_W'($urandom_range(int'(CFG_USA_COUNT) + 1, 255)),
                      16'($urandom));
        cfg_ch.valid <= 1'b0;
        layouts_written++;
    endtask

    task automatic send_record(input bit shaped, input bit corrupt);
        int unsigned       frame, uw, sw, bad_sector;
        logic [DATA_W-1:0] seq, w;
        frame = record_frame();
        uw = m_usa_offset >> 1;
        sw = m_sector_bytes >> 1;
        seq = 16'($urandom);
        bad_sector = 0;
        if (shaped && corrupt)
        begin
            bad_sector = $urandom_range(0, frame / sw - 1);
            tails_corrupted++;
        end
        for (int unsigned p = 0; p < frame; p++)
        begin
            w = 16'($urandom);
            if (shaped)
            begin
                if (p == uw)
                    w = seq;
                else if (p % sw == sw - 1)
                    w = (corrupt && p / sw == bad_sector) ?
                        seq ^ 16'($urandom_range(1, 65535)) : seq;
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    // result transaction check
    always @(posedge clk)
    begin
        fixup_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: out_word %h last_word %b status %0d",
                       res_ch.out_word, res_ch.last_word, res_ch.status);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.out_word !== want.word)
                begin
                    $error("out_word: expected %h, got %h", want.word, res_ch.out_word);
                    failures++;
                end
                if (res_ch.last_word !== want.last)
                begin
                    $error("last_word: expected %b, got %b", want.last, res_ch.last_word);
                    failures++;
                end
                if (res_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_ch.status);
                    failures++;
                end
                if (want.last)
                    records_seen++;
            end
        end
    end

    // receiver stall patterns
    initial
    begin
        ready_style_t style;
        int           span;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            style = steady ? RDY_ALWAYS : ready_style_t'($urandom_range(0, 3));
            span = $urandom_range(4, 40);
            for (int k = 0; k < span; k++)
            begin
                case (style)
                    RDY_ALWAYS:   res_ch.ready <= 1'b1;
                    RDY_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_MOSTLY:   res_ch.ready <= ($urandom_range(0, 7) != 0);
                    RDY_PERIODIC: res_ch.ready <= ((k % 6) >= 3);
                    default:      res_ch.ready <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned sb, rb, off, cnt, n;
        int          shape;
        logic [3:0]  which;
        bit          shaped;

        rst_n <= 1'b0;
        rec_ch.valid <= 1'b0;
        rec_ch.data_word <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        failures = 0;
        words_sent = 0;
        records_seen = 0;
        layouts_written = 0;
        tails_corrupted = 0;
        burst_left = 0;
        steady = 1'b0;
        m_sector_bytes = RST_SECTOR_BYTES;
        m_record_bytes = RST_RECORD_BYTES;
        m_usa_offset = RST_USA_OFFSET;
        m_usa_count = RST_USA_COUNT;
        rec_pos = '0;
        sect_pos = '0;
        sect_idx = '0;
        seq_word = '0;
        tail_fault = ST_OK;
        foreach (tail_orig[i])
            tail_orig[i] = '0;

        directed_steps = '{
            row_layout(6, 6, 0, 2),
            row_check(16'hFFFF, 16'hFFFF, 1'b0, ST_OK),
            row_check(16'h0000, 16'h0000, 1'b0, ST_OK),
            row_check(16'hFFFF, 16'h0000, 1'b1, ST_OK),
            row_check(16'h0000, 16'h0000, 1'b0, ST_OK),
            row_check(16'hFFFF, 16'hFFFF, 1'b0, ST_OK),
            row_check(16'h1234, 16'h1234, 1'b1, ST_MISMATCH),
            // zero sector size
            row_layout(0, 6, 0, 2),
            row_check(16'hAAAA, 16'hAAAA, 1'b0, ST_OK),
            row_check(16'h5555, 16'h5555, 1'b0, ST_OK),
            row_check(16'hFFFF, 16'hFFFF, 1'b1, ST_BAD_GEOMETRY),
            // zero record length, one-word record
            row_layout(6, 0, 0, 2),
            row_check(16'h0001, 16'h0001, 1'b1, ST_BAD_GEOMETRY),
            row_layout(2, 2, 0, 1),
            row_check(16'h8000, 16'h8000, 1'b1, ST_BAD_GEOMETRY),
            row_layout(2, 2, 0, 3),
            row_check(16'h7FFF, 16'h7FFF, 1'b1, ST_BAD_GEOMETRY),
            // array offset past the record
            row_layout(2, 2, 4, 2),
            row_check(16'hFFFE, 16'hFFFE, 1'b1, ST_BAD_GEOMETRY),
            // array runs off the record end
            row_layout(4, 4, 2, 2),
            row_check(16'h0F0F, 16'h0F0F, 1'b0, ST_OK),
            row_check(16'hF0F0, 16'hF0F0, 1'b1, ST_BAD_GEOMETRY),
            // odd sector size
            row_layout(7, 7, 0, 2),
            row_check(16'h0000, 16'h0000, 1'b0, ST_OK),
            row_check(16'h0000, 16'h0000, 1'b0, ST_OK),
            row_check(16'h0000, 16'h0000, 1'b1, ST_UNSUPPORTED),
            // odd array offset
            row_layout(8, 8, 1, 2),
            row_word(16'h0102),
            row_word(16'h0304),
            row_word(16'h0506),
            row_check(16'h0102, 16'h0102, 1'b1, ST_UNSUPPORTED),
            // array overlapping the first sector tail
            row_layout(8, 8, 4, 2),
            row_word(16'hCAFE),
            row_word(16'hCAFE),
            row_word(16'hCAFE),
            row_check(16'hCAFE, 16'hCAFE, 1'b1, ST_UNSUPPORTED)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one record under the reset layout
        send_record(1'b1, 1'b0);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_LAYOUT)
                program_layout(directed_steps[i].sb, directed_steps[i].rb,
                               directed_steps[i].off, directed_steps[i].cnt, 4'hF, 1'b0);
            else
                send_word(directed_steps[i].word, directed_steps[i].typed,
                          directed_steps[i].want);
        end

        while (words_sent < ITEM_TARGET - LONG_REC_BYTES / 2)
        begin
            steady = ($urandom_range(0, 4) == 0);
            shape = $urandom_range(0, 9);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
            off = 2 * $urandom_range(0, 6);
            cnt = n + 1;
            sb = off + 2 * cnt + 2;
            if ($urandom_range(0, 3) != 0)
                sb += 2 * $urandom_range(1, (n > 4) ? 2 : 10);
            rb = n * sb;
            which = 4'hF;
            if (shape == 7 || shape == 8)
            begin
                case ($urandom_range(0, 5))
                    0: off = off + 1;
                    1:
                    begin
                        sb = sb + 1;
                        rb = n * sb;
                    end
                    2: cnt = ($urandom_range(0, 1) != 0) ? cnt + 1 : cnt - 1;
                    3: rb = rb + 2;
                    4: off = rb;
                    default: off = sb - 2 * cnt;
                endcase
            end
            else if (shape == 9 && $urandom_range(0, 1) != 0)
            begin
                n = $urandom_range(16, 20);
                sb = 2 * $urandom_range(3, 5);
                rb = n * sb;
                cnt = n + 1;
                off = 0;
                n = 1;
            end
            else if (shape == 9)
            begin
                case ($urandom_range(0, 3))
                    0: sb = 0;
                    1: sb = MAX_REC_BYTES;
                    2: sb = $urandom_range(1, 64);
                    default: sb = $urandom_range(0, MAX_REC_BYTES);
                endcase
                rb = ($urandom_range(0, 3) == 0 && sb <= 160) ? sb : $urandom_range(0, 160);
                case ($urandom_range(0, 3))
                    0: off = 0;
                    1: off = MAX_REC_BYTES;
                    2: off = $urandom_range(0, rb + 4);
                    default: off = $urandom_range(0, MAX_REC_BYTES);
                endcase
                case ($urandom_range(0, 4))
                    0: cnt = 0;
                    1: cnt = 1;
                    2: cnt = 65535;
                    3: cnt = $urandom_range(0, 20);
                    default: cnt = $urandom_range(0, 65535);
                endcase
                which = 4'($urandom_range(1, 15));
                n = 1;
            end
            program_layout(sb, rb, off, cnt, which, $urandom_range(0, 7) == 0);
            shaped = (layout_status() == ST_OK) && ($urandom_range(0, 9) != 0);
            repeat ((n > 4) ? 1 : $urandom_range(1, 4))
                send_record(shaped, $urandom_range(0, 5) == 0);
        end

        // long record of four sectors
        steady = 1'b0;
        program_layout(256, LONG_REC_BYTES, 48, 5, 4'hF, 1'b0);
        send_record(1'b1, $urandom_range(0, 1) != 0);

        rec_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d record words in %0d records over %0d register settings",
                 words_sent, records_seen, layouts_written);
        $display("%0d well-formed records carried a corrupted sector tail", tails_corrupted);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
